// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent implication checked on the rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked on the rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/v4mu_pkg.sv
// Package with command codes and the fixed field widths of the vector unit.
`default_nettype none
package v4mu_pkg;
  localparam int unsigned FieldW = 32;
  localparam int unsigned CmdW   = 4;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD   = 4'd0,
    CMD_SUB   = 4'd1,
    CMD_SCALE = 4'd2,
    CMD_DOT   = 4'd3,
    CMD_CROSS = 4'd4,
    CMD_LEN   = 4'd5,
    CMD_NORM  = 4'd6,
    CMD_LOAD  = 4'd7,
    CMD_VXM   = 4'd8
  } cmd_e;
endpackage
`default_nettype wire

// File: rtl/v4mu_divsqrt.sv
// Shared radix-2 unit: restoring unsigned division or floor square root.
`default_nettype none
`include "assert_macros.svh"
module v4mu_divsqrt #(
  parameter int unsigned W = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic         sqrt_i,
  input  wire logic [W-1:0] num_i,
  input  wire logic [W-1:0] den_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [W-1:0]      res_o
);
  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0]    num_q, num_d, res_q, res_d, den_q;
  logic [W+1:0]    rem_q, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d, sqrt_q;
  logic [W+1:0]    trial, shifted;

  // Division shifts in one numerator bit per step; square root shifts in two.
  always_comb begin
    if (sqrt_q) begin
      shifted = {rem_q[W-1:0], num_q[W-1 -: 2]};
      trial   = {res_q, 2'b01};
    end else begin
      shifted = {rem_q[W:0], num_q[W-1]};
      trial   = {2'b00, den_q};
    end
    num_d  = sqrt_q ? (num_q << 2) : (num_q << 1);
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    res_d  = res_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = sqrt_i ? CntW'(W / 2) : CntW'(W);
      rem_d  = '0;
      res_d  = '0;
      num_d  = num_i;
    end else if (busy_q) begin
      if (shifted >= trial) begin
        rem_d = shifted - trial;
        res_d = {res_q[W-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        res_d = {res_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    res_q <= res_d;
    if (start_i && !busy_q) begin
      den_q  <= den_i;
      sqrt_q <= sqrt_i;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign res_o  = res_q;

  `ASSERT_NEXT(a_done_after_busy, clk_i, rst_ni, done_q, !busy_q)
  `ASSERT_IMPL(a_cnt_live, clk_i, rst_ni, busy_q, cnt_q != '0)
endmodule
`default_nettype wire

// File: rtl/vector4_math_unit.sv
// Top level of the four component fixed-point vector unit.
//
//  channel | signals                                   | direction
//  in      | in_valid_i/in_ready_o, cmd_i..b3_i        | request in
//  out     | out_valid_o/out_ready_i, r0_o..zero_length_o | result out
//
// One request is taken at a time; the unit is not ready until its result leaves.
// Add and sub step through the components on the shared adder; product commands
// use one shared multiplier, one product at a time (up to 16 for vector times matrix, plus adds).
// Length and normalize run on the shared bit-serial divide/square-root unit
// (one bit per cycle, 64 bit operands).
// Reset clears the control and the matrix store; output stalls hold the result.
`default_nettype none
`include "assert_macros.svh"
module vector4_math_unit
  import v4mu_pkg::*;
#(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [3:0]        cmd_i,
  input  wire logic [2:0]        dims_i,
  input  wire logic [1:0]        col_index_i,
  input  wire logic signed [31:0] a0_i, a1_i, a2_i, a3_i,
  input  wire logic signed [31:0] b0_i, b1_i, b2_i, b3_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic signed [31:0]     r0_o, r1_o, r2_o, r3_o,
  output logic                   overflow_o,
  output logic                   zero_length_o
);
  localparam int unsigned EW = (DATA_WIDTH < FieldW) ? DATA_WIDTH : FieldW;
  localparam int unsigned PW = 2 * EW;
  localparam int unsigned DW = 64;
  localparam logic signed [PW+1:0] VMax = (PW+2)'((65'sd1 <<< (EW - 1)) - 1);
  localparam logic signed [PW+1:0] VMin = -VMax - 1;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_MUL, S_ACC, S_CROSS, S_SQRT, S_SQWAIT, S_DIV, S_DIVWAIT,
    S_OUT
  } state_e;

  typedef logic signed [EW-1:0] val_t;

  state_e        state_q;
  cmd_e          cmd_q;
  logic [2:0]    n_q;
  val_t          a_q [4];
  val_t          b_q [4];
  val_t          r_q [4];
  val_t          mat_q [16];
  val_t          p_q [6];
  logic [4:0]    k_q;
  logic [1:0]    j_q;
  logic signed [PW+1:0] acc_q;
  logic          ovf_q, zl_q, busy_st;
  logic [DW-1:0] len_q;

  // Shared multiplier with floor shift and saturation.
  val_t                 mx, my;
  logic signed [PW-1:0] prod;
  logic signed [PW+1:0] prod_sh, sum_in_a, sum_in_b, sum_w;
  val_t                 prod_sat, sum_sat;
  logic                 prod_ovf, sum_ovf;

  logic [3:0] mk;
  assign mk = k_q[3:0];

  always_comb begin
    mx = a_q[mk[1:0]];
    my = b_q[mk[1:0]];
    case (cmd_q)
      CMD_SCALE: my = b_q[0];
      CMD_VXM:   my = mat_q[{mk[1:0], j_q}];
      CMD_CROSS: begin
        case (mk[2:0])
          3'd0: begin mx = a_q[1]; my = b_q[2]; end
          3'd1: begin mx = a_q[2]; my = b_q[1]; end
          3'd2: begin mx = a_q[2]; my = b_q[0]; end
          3'd3: begin mx = a_q[0]; my = b_q[2]; end
          3'd4: begin mx = a_q[0]; my = b_q[1]; end
          default: begin mx = a_q[1]; my = b_q[0]; end
        endcase
      end
      CMD_LEN, CMD_NORM: my = a_q[mk[1:0]];
      default: ;
    endcase
  end

  assign prod    = PW'(mx) * PW'(my);
  assign prod_sh = (PW+2)'(prod >>> FRAC_BITS);
  assign prod_ovf = (prod_sh > VMax) || (prod_sh < VMin);
  assign prod_sat = (prod_sh > VMax) ? val_t'(VMax) :
                    (prod_sh < VMin) ? val_t'(VMin) : val_t'(prod_sh);

  // Shared saturating adder.
  logic sub_sel;
  always_comb begin
    sub_sel  = 1'b0;
    sum_in_a = acc_q;
    sum_in_b = (PW+2)'(b_q[mk[1:0]]);
    case (state_q)
      S_ADD: begin
        sum_in_a = (PW+2)'(a_q[mk[1:0]]);
        sub_sel  = (cmd_q == CMD_SUB);
      end
      S_CROSS: begin
        sum_in_a = (PW+2)'(p_q[{mk[1:0], 1'b0}]);
        sum_in_b = (PW+2)'(p_q[{mk[1:0], 1'b1}]);
        sub_sel  = 1'b1;
      end
      default: sum_in_b = (PW+2)'(p_q[0]);
    endcase
    sum_w   = sub_sel ? (sum_in_a - sum_in_b) : (sum_in_a + sum_in_b);
    sum_ovf = (sum_w > VMax) || (sum_w < VMin);
    sum_sat = (sum_w > VMax) ? val_t'(VMax) :
              (sum_w < VMin) ? val_t'(VMin) : val_t'(sum_w);
  end

  // Divider / square root unit.
  logic          du_start, du_sqrt, du_busy, du_done;
  logic [DW-1:0] du_num, du_den, du_res;
  val_t          acc_sat;
  logic [EW-1:0] mag;
  logic signed [DW:0] q_s;

  assign acc_sat = val_t'(acc_q);
  assign mag     = a_q[mk[1:0]][EW-1] ? EW'(-a_q[mk[1:0]]) : EW'(a_q[mk[1:0]]);

  always_comb begin
    du_start = (state_q == S_SQRT) || (state_q == S_DIV);
    du_sqrt  = (state_q == S_SQRT);
    du_num   = du_sqrt ? (DW'($unsigned(acc_sat[EW-1] ? val_t'(0) : acc_sat)) << FRAC_BITS)
                       : (DW'(mag) << FRAC_BITS);
    du_den   = len_q;
  end

  v4mu_divsqrt #(.W(DW)) u_divsqrt (
    .clk_i, .rst_ni,
    .start_i(du_start), .sqrt_i(du_sqrt), .num_i(du_num), .den_i(du_den),
    .busy_o(du_busy), .done_o(du_done), .res_o(du_res)
  );

  logic          q_ovf;
  val_t          q_sat;
  always_comb begin
    q_s   = a_q[mk[1:0]][EW-1] ? -$signed({1'b0, du_res}) : $signed({1'b0, du_res});
    q_ovf = (q_s > (DW+1)'(VMax)) || (q_s < (DW+1)'(VMin));
    q_sat = (q_s > (DW+1)'(VMax)) ? val_t'(VMax) :
            (q_s < (DW+1)'(VMin)) ? val_t'(VMin) : val_t'(q_s);
  end

  logic [2:0] n_in;
  assign n_in    = (dims_i < 3'd2) ? 3'd2 : (dims_i > 3'd4) ? 3'd4 : dims_i;
  assign busy_st = (state_q != S_IDLE) && (state_q != S_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      for (int e = 0; e < 16; e++) mat_q[e] <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q <= cmd_e'(cmd_i);
            n_q   <= n_in;
            a_q[0] <= val_t'(a0_i); a_q[1] <= val_t'(a1_i);
            a_q[2] <= val_t'(a2_i); a_q[3] <= val_t'(a3_i);
            b_q[0] <= val_t'(b0_i); b_q[1] <= val_t'(b1_i);
            b_q[2] <= val_t'(b2_i); b_q[3] <= val_t'(b3_i);
            for (int e = 0; e < 4; e++) r_q[e] <= '0;
            k_q   <= '0;
            j_q   <= '0;
            acc_q <= '0;
            ovf_q <= 1'b0;
            zl_q  <= 1'b0;
            case (cmd_e'(cmd_i))
              CMD_ADD, CMD_SUB: state_q <= S_ADD;
              CMD_SCALE, CMD_DOT, CMD_CROSS, CMD_LEN, CMD_NORM, CMD_VXM:
                state_q <= S_MUL;
              CMD_LOAD: begin
                for (int e = 0; e < 4; e++)
                  mat_q[{e[1:0], col_index_i}] <= val_t'(e == 0 ? a0_i : e == 1 ? a1_i :
                                                        e == 2 ? a2_i : a3_i);
                state_q <= S_OUT;
              end
              default: state_q <= S_OUT;
            endcase
          end
        end
        S_ADD: begin
          r_q[mk[1:0]] <= sum_sat;
          ovf_q <= ovf_q | sum_ovf;
          k_q <= k_q + 1'b1;
          if (mk[1:0] == 2'd3) state_q <= S_OUT;
        end
        S_MUL: begin
          ovf_q <= ovf_q | prod_ovf;
          k_q <= k_q + 1'b1;
          case (cmd_q)
            CMD_SCALE: begin
              r_q[mk[1:0]] <= prod_sat;
              if (mk[1:0] == 2'd3) state_q <= S_OUT;
            end
            CMD_CROSS: begin
              p_q[mk[2:0]] <= prod_sat;
              if (mk[2:0] == 3'd5) begin
                k_q <= '0;
                state_q <= S_CROSS;
              end
            end
            default: begin
              p_q[0] <= prod_sat;
              state_q <= S_ACC;
            end
          endcase
        end
        S_ACC: begin
          // Saturated products add at full width; the final sum saturates once.
          // The count already includes the product added here.
          if ((cmd_q == CMD_VXM) ? (k_q[2:0] == 3'd4) : (k_q[2:0] == n_q)) begin
            case (cmd_q)
              CMD_DOT: begin
                r_q[0] <= sum_sat; ovf_q <= ovf_q | sum_ovf; state_q <= S_OUT;
              end
              CMD_VXM: begin
                r_q[j_q] <= sum_sat; ovf_q <= ovf_q | sum_ovf;
                acc_q <= '0; k_q <= '0; j_q <= j_q + 1'b1;
                state_q <= (j_q == 2'd3) ? S_OUT : S_MUL;
              end
              default: begin
                acc_q <= (PW+2)'(sum_sat); ovf_q <= ovf_q | sum_ovf;
                state_q <= S_SQRT;
              end
            endcase
          end else begin
            acc_q <= sum_w;
            state_q <= S_MUL;
          end
        end
        S_CROSS: begin
          r_q[mk[1:0]] <= sum_sat;
          ovf_q <= ovf_q | sum_ovf;
          k_q <= k_q + 1'b1;
          if (mk[1:0] == 2'd2) state_q <= S_OUT;
        end
        S_SQRT: state_q <= S_SQWAIT;
        S_SQWAIT: begin
          if (du_done) begin
            len_q <= du_res;
            k_q <= '0;
            if (cmd_q == CMD_LEN) begin
              r_q[0] <= val_t'(du_res);
              state_q <= S_OUT;
            end else if (du_res == '0) begin
              zl_q <= 1'b1;
              state_q <= S_OUT;
            end else begin
              state_q <= S_DIV;
            end
          end
        end
        S_DIV: state_q <= S_DIVWAIT;
        S_DIVWAIT: begin
          if (du_done) begin
            r_q[mk[1:0]] <= q_sat;
            ovf_q <= ovf_q | q_ovf;
            k_q <= k_q + 1'b1;
            state_q <= (mk[1:0] == 2'd3) ? S_OUT : S_DIV;
          end
        end
        S_OUT: if (out_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = (state_q == S_OUT);
  assign r0_o          = 32'(r_q[0]);
  assign r1_o          = 32'(r_q[1]);
  assign r2_o          = 32'(r_q[2]);
  assign r3_o          = 32'(r_q[3]);
  assign overflow_o    = ovf_q;
  assign zero_length_o = zl_q;

  `ASSERT_IMPL(a_ready_excl, clk_i, rst_ni, out_valid_o, !in_ready_o)
  `ASSERT_IMPL(a_unit_idle, clk_i, rst_ni, !busy_st, !du_busy)
  `ASSERT_NEXT(a_take_leaves_idle, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
endmodule
`default_nettype wire

// File: verif/vector4_math_unit_checker.sv
// Checker for the vector unit: watches both channels, predicts results and compares them.
module vector4_math_unit_checker
  import v4mu_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_ready_i,
  input  wire logic [3:0]         cmd_i,
  input  wire logic [2:0]         dims_i,
  input  wire logic [1:0]         col_index_i,
  input  wire logic signed [31:0] a0_i, a1_i, a2_i, a3_i,
  input  wire logic signed [31:0] b0_i, b1_i, b2_i, b3_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire logic signed [31:0] r0_i, r1_i, r2_i, r3_i,
  input  wire logic               overflow_i,
  input  wire logic               zero_length_i,
  output int                      errors_o,
  output int                      pending_o,
  output int                      results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FracBits = 16;
  localparam longint VecMax = 64'sd2147483647;
  localparam longint VecMin = -64'sd2147483648;

  typedef struct packed {
    logic [31:0] r0, r1, r2, r3;
    logic        ovf;
    logic        zl;
  } vec_result_t;

  vec_result_t expected_q[$];
  longint      mat[16];
  bit          ovf_flag;

  function automatic longint clamp(longint v);
    if (v > VecMax) begin
      ovf_flag = 1;
      return VecMax;
    end
    if (v < VecMin) begin
      ovf_flag = 1;
      return VecMin;
    end
    return v;
  endfunction

  // Arithmetic right shift of the full product rounds toward minus infinity.
  function automatic longint qmul(longint x, longint y);
    longint p;
    p = x * y;
    return clamp(p >>> FracBits);
  endfunction

  function automatic longint dot_sum(longint x[4], longint y[4], int n);
    longint s;
    s = 0;
    for (int i = 0; i < n; i++) s += qmul(x[i], y[i]);
    return clamp(s);
  endfunction

  function automatic longint vec_len(longint x[4], int n);
    longint d;
    logic [63:0] v, res, bitv;
    d = dot_sum(x, x, n);
    if (d < 0) d = 0;
    v = 64'(d) << FracBits;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic vec_result_t compute_result(logic [3:0] cmd, logic [2:0] dims,
      logic [1:0] ci, longint a[4], longint b[4]);
    longint r[4];
    longint col[4];
    longint len, q;
    logic [63:0] mag;
    int n;
    bit zl;
    vec_result_t res;
    r = '{0, 0, 0, 0};
    zl = 0;
    ovf_flag = 0;
    n = (dims < 2) ? 2 : (dims > 4) ? 4 : int'(dims);
    case (cmd)
      CMD_ADD: for (int i = 0; i < 4; i++) r[i] = clamp(a[i] + b[i]);
      CMD_SUB: for (int i = 0; i < 4; i++) r[i] = clamp(a[i] - b[i]);
      CMD_SCALE: for (int i = 0; i < 4; i++) r[i] = qmul(a[i], b[0]);
      CMD_DOT: r[0] = dot_sum(a, b, n);
      CMD_CROSS: begin
        r[0] = clamp(qmul(a[1], b[2]) - qmul(a[2], b[1]));
        r[1] = clamp(qmul(a[2], b[0]) - qmul(a[0], b[2]));
        r[2] = clamp(qmul(a[0], b[1]) - qmul(a[1], b[0]));
      end
      CMD_LEN: r[0] = vec_len(a, n);
      CMD_NORM: begin
        len = vec_len(a, n);
        if (len == 0) begin
          zl = 1;
        end else begin
          for (int i = 0; i < 4; i++) begin
            mag = 64'(a[i] < 0 ? -a[i] : a[i]);
            q = longint'((mag << FracBits) / 64'(len));
            r[i] = clamp(a[i] < 0 ? -q : q);
          end
        end
      end
      CMD_LOAD: for (int i = 0; i < 4; i++) mat[i * 4 + int'(ci)] = a[i];
      CMD_VXM: begin
        for (int j = 0; j < 4; j++) begin
          for (int i = 0; i < 4; i++) col[i] = mat[i * 4 + j];
          r[j] = dot_sum(a, col, 4);
        end
      end
      default: ;
    endcase
    res.r0 = r[0][31:0];
    res.r1 = r[1][31:0];
    res.r2 = r[2][31:0];
    res.r3 = r[3][31:0];
    res.ovf = ovf_flag;
    res.zl = zl;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    longint a[4], b[4];
    vec_result_t got, want;
    if (!rst_ni) begin
      foreach (mat[i]) mat[i] = 0;
      expected_q.delete();
      errors_o = 0;
      results_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        a = '{longint'(a0_i), longint'(a1_i), longint'(a2_i), longint'(a3_i)};
        b = '{longint'(b0_i), longint'(b1_i), longint'(b2_i), longint'(b3_i)};
        expected_q.push_back(compute_result(cmd_i, dims_i, col_index_i, a, b));
      end
      if (out_valid_i && out_ready_i) begin
        got = '{r0_i, r1_i, r2_i, r3_i, overflow_i, zero_length_i};
        results_o++;
        if (expected_q.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected result %h", $realtime, got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            errors_o++;
            $display("%0t: mismatch expected r=%h %h %h %h ovf=%b zl=%b", $realtime,
                     want.r0, want.r1, want.r2, want.r3, want.ovf, want.zl);
            $display("%0t:          actual   r=%h %h %h %h ovf=%b zl=%b", $realtime,
                     got.r0, got.r1, got.r2, got.r3, got.ovf, got.zl);
          end
        end
      end
    end
    pending_o = expected_q.size();
  end
endmodule

// File: verif/vector4_math_unit_tb.sv
// Testbench top for the vector unit: makes requests, stalls the output and gives the verdict.
module vector4_math_unit_tb;
  import v4mu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic [3:0] cmd_i;
  logic [2:0] dims_i;
  logic [1:0] col_index_i;
  logic signed [31:0] a0_i, a1_i, a2_i, a3_i, b0_i, b1_i, b2_i, b3_i;
  logic signed [31:0] r0_o, r1_o, r2_o, r3_o;
  logic overflow_o, zero_length_o;
  int errors, pending, results;
  int sent;

  vector4_math_unit dut (.*);

  vector4_math_unit_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .cmd_i, .dims_i, .col_index_i,
    .a0_i, .a1_i, .a2_i, .a3_i, .b0_i, .b1_i, .b2_i, .b3_i,
    .out_valid_i(out_valid_o), .out_ready_i, .r0_i(r0_o), .r1_i(r1_o), .r2_i(r2_o),
    .r3_i(r3_o), .overflow_i(overflow_o), .zero_length_i(zero_length_o),
    .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Operand values biased toward extremes, small values and Q16.16 units.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(0, 8)) - 4) << 16;
      3: return 32'($urandom_range(0, 255)) - 32'd128;
      4: return 32'($signed($urandom_range(0, 2000)) - 1000) << 10;
      default: return $urandom;
    endcase
  endfunction

  // Valid stays high into the next request when there is no gap.
  task automatic send(logic [3:0] cmd, logic [2:0] dims, logic [1:0] ci,
      logic [31:0] a[4], logic [31:0] b[4]);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1;
    cmd_i <= cmd;
    dims_i <= dims;
    col_index_i <= ci;
    {a0_i, a1_i, a2_i, a3_i} <= {a[0], a[1], a[2], a[3]};
    {b0_i, b1_i, b2_i, b3_i} <= {b[0], b[1], b[2], b[3]};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
  endtask

  task automatic send_random(logic [3:0] cmd);
    logic [31:0] a[4], b[4];
    foreach (a[i]) begin
      a[i] = pick_value();
      b[i] = pick_value();
    end
    send(cmd, 3'($urandom), 2'($urandom), a, b);
  endtask

  // Output stalls: random ready with long holds now and then.
  initial begin
    int g;
    out_ready_i = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 2) == 0) begin
        g = gap_len();
        if (g > 0) begin
          out_ready_i <= 0;
          repeat (g) @(posedge clk_i);
        end
      end
      out_ready_i <= 1;
    end
  end

  initial begin
    logic [31:0] a[4], b[4];
    logic [31:0] mx, mn, one;
    int p;
    logic [3:0] cmd;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    one = 32'h00010000;
    sent = 0;
    rst_ni = 0;
    in_valid_i = 0;
    cmd_i = 0;
    dims_i = 2;
    col_index_i = 0;
    {a0_i, a1_i, a2_i, a3_i, b0_i, b1_i, b2_i, b3_i} = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: product on a zero matrix, extremes, every command, zero normalize.
    a = '{one, one, one, one};
    send(CMD_VXM, 3'd4, 2'd0, a, a);
    a = '{mx, mn, mx, mn};
    b = '{mx, mx, mn, mn};
    send(CMD_ADD, 3'd4, 2'd0, a, b);
    send(CMD_SUB, 3'd4, 2'd0, a, b);
    send(CMD_SCALE, 3'd4, 2'd0, a, b);
    send(CMD_DOT, 3'd4, 2'd0, a, b);
    send(CMD_DOT, 3'd0, 2'd0, a, b);
    send(CMD_DOT, 3'd7, 2'd0, a, b);
    send(CMD_CROSS, 3'd1, 2'd0, a, b);
    send(CMD_LEN, 3'd4, 2'd0, a, b);
    send(CMD_NORM, 3'd3, 2'd0, a, b);
    a = '{0, 0, 0, 32'd5};
    send(CMD_NORM, 3'd3, 2'd0, a, b);
    a = '{32'd1, 0, 0, 0};
    send(CMD_NORM, 3'd2, 2'd0, a, b);
    a = '{one, 32'hfffe0000, 32'h00030000, 32'h7fffffff};
    send(CMD_NORM, 3'd4, 2'd0, a, b);
    send(CMD_LEN, 3'd2, 2'd0, a, b);
    for (int c = 0; c < 4; c++) begin
      a = '{32'(c + 1) << 16, 32'hffff0000, 32'(c) << 15, mx};
      send(CMD_LOAD, 3'd4, 2'(c), a, b);
    end
    a = '{one, 32'hffff8000, 32'h00020000, 32'd3};
    send(CMD_VXM, 3'd2, 2'd0, a, b);
    send(4'd9, 3'd4, 2'd0, a, b);
    send(4'd15, 3'd4, 2'd3, a, b);
    in_valid_i <= 0;
    @(posedge clk_i);

    // Pause until every result has come back.
    while (pending != 0) @(posedge clk_i);

    for (int k = 0; k < 480; k++) begin
      p = $urandom_range(0, 99);
      if (p < 8) cmd = CMD_LOAD;
      else if (p < 18) cmd = CMD_VXM;
      else if (p < 24) cmd = CMD_NORM;
      else if (p < 30) cmd = CMD_LEN;
      else if (p < 33) cmd = 4'($urandom_range(9, 15));
      else cmd = 4'($urandom_range(0, 4));
      send_random(cmd);
    end
    in_valid_i <= 0;

    fork
      begin
        while (pending != 0) @(posedge clk_i);
        repeat (400) @(posedge clk_i);
      end
      begin
        #20ms;
        $display("tb: failure");
        $finish;
      end
    join_any
    $display("Sent %0d requests over all commands, column loads and unused codes;", sent);
    $display("checked %0d results under random input gaps and output stalls.", results);
    if (errors == 0 && pending == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #50ms;
    $display("tb: failure");
    $finish;
  end
endmodule

// File: vector4_math_unit.f
+incdir+rtl
rtl/v4mu_pkg.sv
rtl/v4mu_divsqrt.sv
rtl/vector4_math_unit.sv
verif/vector4_math_unit_checker.sv
verif/vector4_math_unit_tb.sv
